// ===== src/ple_pkg.sv =====
package ple_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned CmpW     = ((CntW > 5) ? CntW : 5) + 1;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_DUMP      = 3'd6
  } act_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [4:0]         position;
  } ple_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         element_count;
    logic signed [31:0] element_value;
    logic               is_last;
  } ple_out_t;

  typedef struct packed {
    cell_op_e          op;
    logic [IdxW-1:0]   slot;
    logic [CntW-1:0]   len;
    logic signed [31:0] value;
  } ple_ctl_t;

endpackage

// ===== src/ple_cell.sv =====
module ple_cell (
  input  logic               clk_i,
  input  ple_pkg::ple_ctl_t  ctl_i,
  input  logic [ple_pkg::IdxW-1:0] idx_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  input  logic signed [31:0] head_i,
  output logic signed [31:0] data_o
);

  logic signed [31:0] data_q, data_d;
  logic [ple_pkg::CntW-1:0] idx_ext;
  logic [ple_pkg::CntW-1:0] tail;

  assign idx_ext = ple_pkg::CntW'(idx_i);
  assign tail    = ctl_i.len - 1'b1;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      ple_pkg::OP_INS: begin
        if (idx_i == ctl_i.slot) begin
          data_d = ctl_i.value;
        end else if (idx_i > ctl_i.slot) begin
          data_d = left_i;
        end
      end
      ple_pkg::OP_DEL: begin
        if (idx_i >= ctl_i.slot) begin
          data_d = right_i;
        end
      end
      ple_pkg::OP_ROT: begin
        if (idx_ext == tail) begin
          data_d = head_i;
        end else if (idx_ext < tail) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== src/ple_chain.sv =====
module ple_chain (
  input  logic               clk_i,
  input  ple_pkg::ple_ctl_t  ctl_i,
  output logic signed [31:0] head_o
);

  logic signed [31:0] data [ple_pkg::Capacity];

  for (genvar g = 0; g < ple_pkg::Capacity; g++) begin : g_cell
    logic signed [31:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = data[g-1];
    end
    if (g == ple_pkg::Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[g+1];
    end
    ple_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .idx_i  (ple_pkg::IdxW'(g)),
      .left_i (left),
      .right_i(right),
      .head_i (data[0]),
      .data_o (data[g])
    );
  end

  assign head_o = data[0];

endmodule

// ===== src/positional_list_engine_core.sv =====
// Positional list engine: an ordered list of up to 16 signed 32-bit words held in a
// chain of shifting cells. A command is taken when start is high and busy is low.
// Every insert, delete or undefined action returns one result word, strobed the
// cycle after the command, and the block can take a new command in that same
// cycle: one command per clock while no dump holds busy high. A dump returns
// one word per element on consecutive cycles (one word, status empty, for an
// empty list), the first in the cycle after the command; busy stays high until
// the final word is strobed. There is no way to stall results: the receiver
// must take each word in the cycle strobe is high.
module positional_list_engine_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ple_pkg::ple_in_t cmd_i,
  output logic             strobe,
  output ple_pkg::ple_out_t res_o
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e state_q, state_d;
  logic [ple_pkg::CntW-1:0] len_q, len_d;
  logic [ple_pkg::IdxW-1:0] dcnt_q, dcnt_d;
  logic strobe_q, strobe_d;
  ple_pkg::ple_out_t res_q, res_d;
  ple_pkg::ple_ctl_t ctl;
  logic signed [31:0] head;
  logic accept, full, empty;
  logic [ple_pkg::CmpW-1:0] pos_w, len_w;
  ple_pkg::status_e st;

  assign accept = start && (state_q == S_IDLE);
  assign full   = (len_q >= ple_pkg::CntW'(ple_pkg::Capacity));
  assign empty  = (len_q == '0);
  assign pos_w  = ple_pkg::CmpW'(cmd_i.position);
  assign len_w  = ple_pkg::CmpW'(len_q);

  ple_chain u_chain (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .head_o(head)
  );

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    dcnt_d   = dcnt_q;
    strobe_d = 1'b0;
    st       = ple_pkg::ST_OK;
    ctl.op    = ple_pkg::OP_HOLD;
    ctl.slot  = '0;
    ctl.len   = len_q;
    ctl.value = cmd_i.value;
    res_d.status        = ple_pkg::ST_OK;
    res_d.element_count = 5'(len_q);
    res_d.element_value = '0;
    res_d.is_last       = 1'b1;

    if (state_q == S_DUMP) begin
      ctl.op              = ple_pkg::OP_ROT;
      strobe_d            = 1'b1;
      res_d.element_value = head;
      res_d.is_last       = (ple_pkg::CntW'(dcnt_q) == len_q - 1'b1);
      dcnt_d              = dcnt_q + 1'b1;
      if (res_d.is_last) begin
        state_d = S_IDLE;
      end
    end else if (accept) begin
      strobe_d = 1'b1;
      unique case (cmd_i.action) inside
        ple_pkg::ACT_INS_FRONT, ple_pkg::ACT_INS_BACK, ple_pkg::ACT_INS_AT: begin
          if (cmd_i.action == ple_pkg::ACT_INS_AT &&
              (pos_w == '0 || pos_w > len_w + 1'b1)) begin
            st = ple_pkg::ST_INVALID;
          end else if (full) begin
            st = ple_pkg::ST_FULL;
          end else begin
            ctl.op = ple_pkg::OP_INS;
            if (cmd_i.action == ple_pkg::ACT_INS_BACK) begin
              ctl.slot = ple_pkg::IdxW'(len_q);
            end else if (cmd_i.action == ple_pkg::ACT_INS_AT) begin
              ctl.slot = ple_pkg::IdxW'(cmd_i.position - 1'b1);
            end
            len_d = len_q + 1'b1;
          end
        end
        ple_pkg::ACT_DEL_FRONT, ple_pkg::ACT_DEL_BACK, ple_pkg::ACT_DEL_AT: begin
          if (empty) begin
            st = ple_pkg::ST_EMPTY;
          end else if (cmd_i.action == ple_pkg::ACT_DEL_AT &&
                       (pos_w == '0 || pos_w > len_w)) begin
            st = ple_pkg::ST_INVALID;
          end else begin
            ctl.op = ple_pkg::OP_DEL;
            if (cmd_i.action == ple_pkg::ACT_DEL_BACK) begin
              ctl.slot = ple_pkg::IdxW'(len_q - 1'b1);
            end else if (cmd_i.action == ple_pkg::ACT_DEL_AT) begin
              ctl.slot = ple_pkg::IdxW'(cmd_i.position - 1'b1);
            end
            len_d = len_q - 1'b1;
          end
        end
        ple_pkg::ACT_DUMP: begin
          if (empty) begin
            st = ple_pkg::ST_EMPTY;
          end else begin
            // first word leaves now, the ring rotates once per word
            ctl.op              = ple_pkg::OP_ROT;
            res_d.element_value = head;
            res_d.is_last       = (len_q == ple_pkg::CntW'(1));
            dcnt_d              = ple_pkg::IdxW'(1);
            if (!res_d.is_last) begin
              state_d = S_DUMP;
            end
          end
        end
        default: st = ple_pkg::ST_INVALID;
      endcase
      res_d.status        = st;
      res_d.element_count = 5'(len_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      len_q    <= '0;
      dcnt_q   <= '0;
      strobe_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      dcnt_q   <= dcnt_d;
      strobe_q <= strobe_d;
      res_q    <= res_d;
    end
  end

  assign busy   = (state_q == S_DUMP);
  assign strobe = strobe_q;
  assign res_o  = res_q;

endmodule

// ===== src/ple_checker.sv =====
module ple_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input ple_pkg::ple_in_t  cmd_i,
  input logic              strobe,
  input ple_pkg::ple_out_t res_o
);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> res_o.element_count <= 5'(ple_pkg::Capacity))
    else $error("element count above capacity");

  a_cmd_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> strobe)
    else $error("accepted command gave no word");

  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.action != ple_pkg::ACT_DUMP) |=> res_o.is_last)
    else $error("non-dump command gave more than one word");

  a_dump_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && !res_o.is_last) |-> busy ##1 strobe)
    else $error("dump stream broke off");

  a_busy_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (strobe && res_o.is_last))
    else $error("busy dropped without final word");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (.*);
